FILE: hdl/tcde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_pkg
// Shared types and constants of the timed command drift encoder.
// ----------------------------------------------------------------------------
package tcde_pkg;

  localparam int unsigned DRIFT_W         = 32;
  localparam int unsigned OPND_W          = 17;
  localparam int unsigned MAX_DELAY_BYTES = 62;
  localparam int unsigned CNT_W           = 6;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 8;
  localparam int unsigned REM_DIGIT_W     = 4;
  localparam int unsigned REM_STEPS       = DRIFT_W / REM_DIGIT_W;
  localparam int unsigned REM_CNT_W       = $clog2(REM_STEPS);

  // Operation codes.
  localparam logic [1:0] OP_DELAY  = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_RESYNC = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_PRE_COST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_POST_COST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FINE_ADJ   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CODE     = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] wait_cycles;
    logic [4:0]  reg_addr;
    logic [7:0]  reg_data;
  } tcde_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       flush_now;
    logic       last;
  } tcde_out_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic               start;
    logic [DRIFT_W-1:0] value;
    logic [3:0]         divisor;
  } tcde_rem_req_t;

endpackage

FILE: hdl/tcde_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_alu
// Shared saturating drift adder with a threshold compare on the raw sum.
// ----------------------------------------------------------------------------
module tcde_alu import tcde_pkg::*; (
  input  logic signed [DRIFT_W-1:0] drift_i,
  input  logic signed [OPND_W-1:0]  opnd_i,
  input  logic [7:0]                thr_i,
  output logic signed [DRIFT_W-1:0] sum_sat_o,
  output logic                      ge_thr_o
);

  logic signed [DRIFT_W:0] sum;

  assign sum = {drift_i[DRIFT_W-1], drift_i}
             + {{(DRIFT_W+1-OPND_W){opnd_i[OPND_W-1]}}, opnd_i};

  always_comb begin
    if (sum[DRIFT_W] != sum[DRIFT_W-1]) begin
      sum_sat_o = sum[DRIFT_W] ? {1'b1, {(DRIFT_W-1){1'b0}}}
                               : {1'b0, {(DRIFT_W-1){1'b1}}};
    end else begin
      sum_sat_o = sum[DRIFT_W-1:0];
    end
  end

  assign ge_thr_o = (sum >= $signed({{(DRIFT_W-7){1'b0}}, thr_i}));

endmodule

FILE: hdl/tcde_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcde_rem
// Digit-serial remainder of the drift by a small divisor, four bits a cycle.
// ----------------------------------------------------------------------------
module tcde_rem import tcde_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  tcde_rem_req_t req_i,
  output logic          busy_o,
  output logic [2:0]    rem_o
);

  logic                 busy_r, busy_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DRIFT_W-1:0]   val_r, val_nxt;
  logic [3:0]           div_r, div_nxt;
  logic [3:0]           rem_r, rem_nxt;
  logic [3:0]           step_rem;

  // The partial remainder stays below the divisor, so it fits four bits.
  always_comb begin
    logic [4:0] r2;
    step_rem = rem_r;
    for (int k = REM_DIGIT_W - 1; k >= 0; k--) begin
      r2 = {step_rem, val_r[DRIFT_W - REM_DIGIT_W + k]};
      if (r2 >= {1'b0, div_r}) begin
        r2 = r2 - {1'b0, div_r};
      end
      step_rem = r2[3:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = req_i.value;
      div_nxt  = req_i.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = step_rem;
      val_nxt = {val_r[DRIFT_W-REM_DIGIT_W-1:0], {REM_DIGIT_W{1'b0}}};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == REM_CNT_W'(REM_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy_o = busy_r;
  assign rem_o  = rem_r[2:0];

endmodule

FILE: hdl/timed_command_drift_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_drift_encoder_core
// Turns timed chip-register commands into a command byte stream, spending
// accumulated clock drift as delay bytes and fine address delay bits.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    tcde_in_t  (one command)
//   out_     output     out_valid / out_stall  tcde_out_t (one command byte)
//   cfg_     input      cfg_wen                cfg_index, cfg_wdata
//
// One request is worked on at a time; in_stall is high from acceptance until
// the sequencer is back in its idle state. A resync clears the drift in the
// idle state. A delay adds the wait, then spends the drift as delay bytes.
// A write or read adds the cost subtraction, a start step and a wait on the
// remainder unit (eight steps of four drift bits, then picking up the
// result), then the address byte and, for a write, the data byte; a read
// also adds the offset and the post-cost steps. Every drift update but the
// resync clear goes through the shared drift adder. Reset (synchronous,
// active low) clears the drift, loads the register defaults and empties the
// output register. A stall on the output holds the sequencer in place until
// the pending byte can be handed on.
//
module timed_command_drift_encoder_core import tcde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tcde_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcde_out_t             out_data,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_ADD_OFS   = 4'd1;
  localparam logic [3:0] ST_ADD_WAIT  = 4'd2;
  localparam logic [3:0] ST_SPEND     = 4'd3;
  localparam logic [3:0] ST_SUB_COST  = 4'd4;
  localparam logic [3:0] ST_REM_START = 4'd5;
  localparam logic [3:0] ST_REM_WAIT  = 4'd6;
  localparam logic [3:0] ST_SUB_POST  = 4'd7;
  localparam logic [3:0] ST_EMIT_ADDR = 4'd8;
  localparam logic [3:0] ST_EMIT_DATA = 4'd9;

  // Configuration registers.
  logic [7:0] write_cost_r;
  logic [7:0] read_pre_cost_r;
  logic [7:0] read_post_cost_r;
  logic [3:0] read_offset_r;
  logic [7:0] min_delay_r;
  logic [2:0] max_fine_adj_r;
  logic [7:0] delay_code_r;

  // Sequencer and datapath registers.
  logic [3:0]                state_r, state_nxt;
  logic signed [DRIFT_W-1:0] drift_r, drift_nxt;
  tcde_in_t                  req_r, req_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      pend_r, pend_nxt;
  logic [2:0]                fine_r, fine_nxt;
  logic                      out_valid_r, out_valid_nxt;
  tcde_out_t                 out_data_r, out_data_nxt;

  logic signed [OPND_W-1:0]  alu_opnd;
  logic signed [DRIFT_W-1:0] alu_sum;
  logic                      alu_ge;
  logic [7:0]                thr;
  logic                      out_free;
  logic                      spend_ok;
  tcde_rem_req_t             rem_req;
  logic                      rem_busy;
  logic [2:0]                rem_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_cost_r     <= 8'd16;
      read_pre_cost_r  <= 8'd8;
      read_post_cost_r <= 8'd8;
      read_offset_r    <= 4'hE;
      min_delay_r      <= 8'd20;
      max_fine_adj_r   <= 3'd7;
      delay_code_r     <= 8'd0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_WRITE_COST:     write_cost_r     <= cfg_wdata;
        CFG_READ_PRE_COST:  read_pre_cost_r  <= cfg_wdata;
        CFG_READ_POST_COST: read_post_cost_r <= cfg_wdata;
        CFG_READ_OFFSET:    read_offset_r    <= cfg_wdata[3:0];
        CFG_MIN_DELAY:      min_delay_r      <= cfg_wdata;
        CFG_MAX_FINE_ADJ:   max_fine_adj_r   <= cfg_wdata[2:0];
        CFG_DELAY_CODE:     delay_code_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The spend threshold is the read pre-cost for reads and the write cost
  // otherwise; for a write or read the same value is later taken off the drift.
  assign thr = (req_r.operation == OP_READ) ? read_pre_cost_r : write_cost_r;

  // Operand of the shared adder, chosen by the step in progress.
  always_comb begin
    case (state_r)
      ST_ADD_OFS:  alu_opnd = {{(OPND_W-4){read_offset_r[3]}}, read_offset_r};
      ST_ADD_WAIT: alu_opnd = {1'b0, req_r.wait_cycles};
      ST_SPEND:    alu_opnd = -$signed({{(OPND_W-8){1'b0}}, min_delay_r});
      ST_SUB_COST: alu_opnd = -$signed({{(OPND_W-8){1'b0}}, thr});
      ST_SUB_POST: alu_opnd = -$signed({{(OPND_W-8){1'b0}}, read_post_cost_r});
      default:     alu_opnd = '0;
    endcase
  end

  tcde_alu u_alu (
    .drift_i   (drift_r),
    .opnd_i    (alu_opnd),
    .thr_i     (thr),
    .sum_sat_o (alu_sum),
    .ge_thr_o  (alu_ge)
  );

  // Remainder of the drift by (max_fine_adjust + 1) for the fine delay bits.
  assign rem_req.start   = (state_r == ST_REM_START);
  assign rem_req.value   = drift_r;
  assign rem_req.divisor = {1'b0, max_fine_adj_r} + 4'd1;

  tcde_rem u_rem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (rem_req),
    .busy_o (rem_busy),
    .rem_o  (rem_val)
  );

  // The output register can take a new byte when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Another delay byte is due while (drift - min_delay) stays at or above
  // the threshold, a non-zero delay is set and the byte limit is not hit.
  assign spend_ok = (min_delay_r != 8'd0) && alu_ge
                 && (cnt_r < CNT_W'(MAX_DELAY_BYTES));

  always_comb begin
    state_nxt     = state_r;
    drift_nxt     = drift_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    fine_nxt      = fine_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_data.operation)
            OP_RESYNC: drift_nxt = '0;
            OP_READ:   state_nxt = ST_ADD_OFS;
            default:   state_nxt = ST_ADD_WAIT;
          endcase
        end
      end
      ST_ADD_OFS: begin
        drift_nxt = alu_sum;
        state_nxt = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: begin
        drift_nxt = alu_sum;
        state_nxt = ST_SPEND;
      end
      ST_SPEND: begin
        // One delay byte is held back so that the last one can be marked.
        if (spend_ok) begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.out_byte  = delay_code_r;
              out_data_nxt.flush_now = 1'b0;
              out_data_nxt.last      = 1'b0;
            end
            drift_nxt = alu_sum;
            cnt_nxt   = cnt_r + 1'b1;
            pend_nxt  = 1'b1;
          end
        end else if (!pend_r || out_free) begin
          if (pend_r) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.out_byte  = delay_code_r;
            out_data_nxt.flush_now = 1'b0;
            out_data_nxt.last      = (req_r.operation == OP_DELAY);
          end
          pend_nxt  = 1'b0;
          state_nxt = (req_r.operation == OP_DELAY) ? ST_IDLE : ST_SUB_COST;
        end
      end
      ST_SUB_COST: begin
        drift_nxt = alu_sum;
        state_nxt = ST_REM_START;
      end
      ST_REM_START: begin
        state_nxt = ST_REM_WAIT;
      end
      ST_REM_WAIT: begin
        if (!rem_busy) begin
          // A negative drift carries no fine delay.
          fine_nxt  = drift_r[DRIFT_W-1] ? 3'd0 : rem_val;
          state_nxt = (req_r.operation == OP_READ) ? ST_SUB_POST : ST_EMIT_ADDR;
        end
      end
      ST_SUB_POST: begin
        drift_nxt = alu_sum;
        state_nxt = ST_EMIT_ADDR;
      end
      ST_EMIT_ADDR: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_byte  = {fine_r, req_r.reg_addr};
          out_data_nxt.flush_now = (req_r.operation == OP_READ);
          out_data_nxt.last      = (req_r.operation == OP_READ);
          state_nxt = (req_r.operation == OP_READ) ? ST_IDLE : ST_EMIT_DATA;
        end
      end
      ST_EMIT_DATA: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_byte  = req_r.reg_data;
          out_data_nxt.flush_now = 1'b0;
          out_data_nxt.last      = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drift_r     <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drift_r     <= drift_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    fine_r     <= fine_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed command drift encoder core. A behavioural
// predictor keeps its own drift count and register copies and works out the
// command bytes due for each accepted request. The bytes that the core hands
// on are checked in order against those predictions, while both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import tcde_pkg::*;

  localparam longint     DRIFT_MAX     = 64'sd2147483647;
  localparam longint     DRIFT_MIN     = -64'sd2147483648;
  // Cycles without any handshake before the run is declared hung. The worst
  // correct gap is a sender pause, a full delay burst and a long output stall.
  localparam int         WATCHDOG_MAX  = 4000;
  // Quiet time after the last predicted byte, so that a request that yields no
  // byte (a resync or a short delay) has surely finished inside the core.
  localparam int         SETTLE_CYCLES = 100;
  localparam int         RANDOM_PHASES = 5;
  localparam int         PHASE_ITEMS   = 70;
  // Enough maximum-length delays to build a drift far beyond what the delay
  // byte limit can spend in one request.
  localparam int         BUILD_ITEMS   = 20;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tcde_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  tcde_out_t             out_data;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state: the drift count and a copy of every register.
  longint                drift_count;
  logic [7:0]            cfg_write_cost;
  logic [7:0]            cfg_read_pre;
  logic [7:0]            cfg_read_post;
  logic signed [3:0]     cfg_read_offset;
  logic [7:0]            cfg_min_delay;
  logic [2:0]            cfg_fine_max;
  logic [7:0]            cfg_delay_code;

  // Bytes still owed by the core, oldest first, and the bytes of the request
  // that is being predicted at the moment.
  tcde_out_t             expected_bytes[$];
  tcde_out_t             item_bytes[$];

  int                    mismatch_count = 0;
  int                    idle_cycles    = 0;
  // Idling switches; when on, the sender draws a fresh pause for every request and the sink for every byte.
  logic                  sender_gaps    = 1'b1;
  logic                  sink_gaps      = 1'b1;

  timed_command_drift_encoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // The drift saturates at the signed 32-bit limits after every update.
  function automatic longint sat_drift(input longint value);
    if (value > DRIFT_MAX) return DRIFT_MAX;
    if (value < DRIFT_MIN) return DRIFT_MIN;
    return value;
  endfunction

  function automatic void emit_byte(input logic [7:0] value, input logic flush);
    tcde_out_t b;
    b.out_byte  = value;
    b.flush_now = flush;
    b.last      = 1'b0;
    item_bytes.push_back(b);
  endfunction

  // Whole minimum delays above the threshold go out as delay bytes, at most
  // MAX_DELAY_BYTES of them; whatever is left over stays in the drift. A zero
  // minimum delay sends nothing at all.
  function automatic void spend_drift(input longint threshold);
    longint rest;
    longint step;
    int     sent;
    step = longint'(cfg_min_delay);
    sent = 0;
    if (drift_count <= threshold || step == 0) return;
    rest = drift_count - threshold;
    while (rest >= step && sent < MAX_DELAY_BYTES) begin
      emit_byte(cfg_delay_code, 1'b0);
      sent++;
      rest        = rest - step;
      drift_count = sat_drift(drift_count - step);
    end
  endfunction

  // The fine delay rides in the top three address bits; a negative drift
  // carries no fine delay.
  function automatic logic [7:0] fine_address(input logic [4:0] addr);
    logic [2:0] adj;
    longint     modulus;
    adj     = 3'd0;
    modulus = longint'(cfg_fine_max);
    modulus = modulus + 1;
    if (drift_count >= 0) adj = 3'(drift_count % modulus);
    return {adj, addr};
  endfunction

  function automatic void predict_command(input tcde_in_t req);
    longint     wait_len;
    longint     cost;
    longint     offset;
    logic [7:0] addr_byte;
    tcde_out_t  b;
    item_bytes.delete();
    wait_len = longint'(req.wait_cycles);
    case (req.operation)
      OP_DELAY: begin
        cost        = longint'(cfg_write_cost);
        drift_count = sat_drift(drift_count + wait_len);
        spend_drift(cost);
      end
      OP_WRITE: begin
        cost        = longint'(cfg_write_cost);
        drift_count = sat_drift(drift_count + wait_len);
        spend_drift(cost);
        drift_count = sat_drift(drift_count - cost);
        emit_byte(fine_address(req.reg_addr), 1'b0);
        emit_byte(req.reg_data, 1'b0);
      end
      OP_READ: begin
        offset      = longint'(cfg_read_offset);
        cost        = longint'(cfg_read_pre);
        drift_count = sat_drift(drift_count + offset);
        drift_count = sat_drift(drift_count + wait_len);
        spend_drift(cost);
        drift_count = sat_drift(drift_count - cost);
        addr_byte   = fine_address(req.reg_addr);
        cost        = longint'(cfg_read_post);
        drift_count = sat_drift(drift_count - cost);
        emit_byte(addr_byte, 1'b1);
      end
      default: begin
        drift_count = 0;
      end
    endcase
    foreach (item_bytes[i]) begin
      b      = item_bytes[i];
      b.last = (i == item_bytes.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic void reset_model();
    drift_count     = 0;
    cfg_write_cost  = 8'd16;
    cfg_read_pre    = 8'd8;
    cfg_read_post   = 8'd8;
    cfg_read_offset = -4'sd2;
    cfg_min_delay   = 8'd20;
    cfg_fine_max    = 3'd7;
    cfg_delay_code  = 8'd0;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving and checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: MISMATCH %s", $time, what);
  endtask

  function automatic tcde_in_t make_request(input logic [1:0] op, input int wait_len,
                                            input int addr, input int data);
    tcde_in_t req;
    req.operation   = op;
    req.wait_cycles = wait_len[15:0];
    req.reg_addr    = addr[4:0];
    req.reg_data    = data[7:0];
    return req;
  endfunction

  // Offers one request and predicts its bytes once the core has taken it. It
  // is entered and left at a falling edge; valid is left high so that a
  // back-to-back request does not have to drop it.
  task automatic send_command(input tcde_in_t req);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(req);
    @(negedge clk);
  endtask

  // Holds the input back until every predicted byte has come out.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  // Registers may only change with the core idle, so drain it and then give
  // any request without bytes time to finish.
  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
    case (idx)
      CFG_WRITE_COST:     cfg_write_cost  = value;
      CFG_READ_PRE_COST:  cfg_read_pre    = value;
      CFG_READ_POST_COST: cfg_read_post   = value;
      CFG_READ_OFFSET:    cfg_read_offset = value[3:0];
      CFG_MIN_DELAY:      cfg_min_delay   = value;
      CFG_MAX_FINE_ADJ:   cfg_fine_max    = value[2:0];
      CFG_DELAY_CODE:     cfg_delay_code  = value;
      default: ;
    endcase
  endtask

  task automatic write_all_registers(input int wcost, input int pre, input int post,
                                     input int offs, input int mind, input int fine,
                                     input int code);
    write_register(CFG_WRITE_COST,     wcost[7:0]);
    write_register(CFG_READ_PRE_COST,  pre[7:0]);
    write_register(CFG_READ_POST_COST, post[7:0]);
    write_register(CFG_READ_OFFSET,    offs[7:0]);
    write_register(CFG_MIN_DELAY,      mind[7:0]);
    write_register(CFG_MAX_FINE_ADJ,   fine[7:0]);
    write_register(CFG_DELAY_CODE,     code[7:0]);
  endtask

  task automatic check_result(input tcde_out_t got);
    tcde_out_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h arrived with nothing predicted", got.out_byte));
    end else begin
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                  got.out_byte, want.out_byte));
      if (got.flush_now !== want.flush_now)
        report_mismatch($sformatf("flush_now %b, predicted %b (byte %02h)",
                                  got.flush_now, want.flush_now, want.out_byte));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, predicted %b (byte %02h)",
                                  got.last, want.last, want.out_byte));
    end
  endtask

  // Output side: draws a stall for every byte, then takes the byte on the first
  // rising edge at which it is valid and not stalled.
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = sink_gaps ? $urandom_range(0, 13) : 0;
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      check_result(out_data);
      @(negedge clk);
    end
  end

  // Any request or byte crossing either channel proves the run is still moving.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every operation at the field extremes under the reset register values,
  // including requests that yield no byte, the delay byte limit and reads
  // taken with a negative drift.
  task automatic test_reset_defaults();
    send_command(make_request(OP_RESYNC, 0, 0, 0));
    send_command(make_request(OP_DELAY, 0, 0, 0));
    send_command(make_request(OP_DELAY, 100, 31, 255));
    send_command(make_request(OP_WRITE, 0, 31, 8'hff));
    send_command(make_request(OP_READ, 0, 0, 0));
    send_command(make_request(OP_READ, 65535, 31, 0));
    send_command(make_request(OP_WRITE, 65535, 0, 0));
    send_command(make_request(OP_DELAY, 65535, 21, 8'haa));
    send_command(make_request(OP_RESYNC, 65535, 31, 255));
    send_command(make_request(OP_READ, 0, 21, 8'h55));
    send_command(make_request(OP_WRITE, 0, 10, 8'h5a));
    send_command(make_request(OP_WRITE, 37, 5'h15, 8'ha5));
  endtask

  // Lowest and highest register settings, then a zero minimum delay, which
  // suppresses delay bytes altogether.
  task automatic test_register_extremes();
    settle();
    write_all_registers(0, 0, 0, 8'h08, 1, 0, 0);
    send_command(make_request(OP_DELAY, 65535, 0, 0));
    send_command(make_request(OP_WRITE, 3, 31, 255));
    send_command(make_request(OP_READ, 1, 17, 0));
    send_command(make_request(OP_RESYNC, 0, 0, 0));
    send_command(make_request(OP_READ, 0, 2, 0));
    settle();
    write_all_registers(255, 255, 255, 8'h07, 255, 7, 255);
    send_command(make_request(OP_DELAY, 65535, 0, 0));
    send_command(make_request(OP_WRITE, 300, 9, 8'h3c));
    send_command(make_request(OP_READ, 65535, 30, 0));
    send_command(make_request(OP_READ, 0, 1, 0));
    settle();
    write_register(CFG_MIN_DELAY, 8'd0);
    send_command(make_request(OP_DELAY, 65535, 0, 0));
    send_command(make_request(OP_WRITE, 65535, 7, 8'hc3));
    send_command(make_request(OP_READ, 1000, 24, 0));
  endtask

  function automatic tcde_in_t random_request();
    int pick;
    int wait_len;
    pick = $urandom_range(0, 99);
    if (pick < 50)      wait_len = $urandom_range(0, 63);
    else if (pick < 80) wait_len = $urandom_range(0, 1023);
    else if (pick < 95) wait_len = $urandom_range(0, 65535);
    else                wait_len = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    pick = $urandom_range(0, 99);
    return make_request(pick < 15 ? OP_DELAY : pick < 55 ? OP_WRITE :
                        pick < 90 ? OP_READ : OP_RESYNC,
                        wait_len, $urandom_range(0, 31), $urandom_range(0, 255));
  endfunction

  // Random traffic under several register settings: the reset values first,
  // then random ones. Idling on each side is switched in stretches, and now
  // and then the sender holds back until every byte has come out.
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == 0)
        write_all_registers(16, 8, 8, 8'h0e, 20, 7, 0);
      else
        write_all_registers($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255),
                            ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) begin
          sender_gaps = 1'($urandom_range(0, 1));
          sink_gaps   = 1'($urandom_range(0, 1));
        end
        if (n == 40 || $urandom_range(0, 29) == 0) wait_for_results();
        send_command(random_request());
      end
    end
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
  endtask

  // With no delay bytes to spend it, the drift builds up to a large value. The
  // fine bits of the following write and read show that value, and a delay
  // afterwards runs into the delay byte limit.
  task automatic test_large_drift();
    settle();
    write_all_registers(0, 3, 5, 8'h01, 0, 6, 8'h81);
    sender_gaps = 1'b0;
    send_command(make_request(OP_RESYNC, 0, 0, 0));
    for (int n = 0; n < BUILD_ITEMS; n++)
      send_command(make_request(OP_DELAY, 65535, n, n));
    send_command(make_request(OP_WRITE, 65535, 19, 8'h66));
    send_command(make_request(OP_READ, 65535, 12, 0));
    settle();
    write_register(CFG_MIN_DELAY, 8'd255);
    send_command(make_request(OP_DELAY, 0, 0, 0));
    send_command(make_request(OP_WRITE, 0, 4, 8'h99));
    send_command(make_request(OP_RESYNC, 0, 0, 0));
    send_command(make_request(OP_WRITE, 0, 4, 8'h99));
    sender_gaps = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_model();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_large_drift();

    // Let the last bytes drain, then allow for any trailing activity.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
